/* design/lvk_pkg.sv */
// Shared types and constants of the learned volume key controller.
`default_nettype none
package lvk_pkg;

  localparam int FIELD_W     = 8;
  localparam int STEP_W      = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;
  localparam int BUTTONS_DEF = 8;

  localparam logic [FIELD_W-1:0] VOLUME_RESET  = 8'd85;
  localparam logic [STEP_W-1:0]  STEP_RESET    = 7'd10;
  localparam logic [FIELD_W-1:0] CEILING_RESET = 8'd100;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME_CEILING = 1'b1;

  // One edge bit presented by the scanner in a cycle.
  typedef struct packed {
    logic               hit;
    logic [FIELD_W-1:0] key;   // one-hot position of the bit under scan
  } press_t;

  // Current controller state seen by the output stage.
  typedef struct packed {
    logic [FIELD_W-1:0] volume;
    logic [FIELD_W-1:0] up_mask;
    logic [FIELD_W-1:0] down_key;
    logic               changed;
  } status_t;

endpackage
`default_nettype wire

/* design/lvk_in_if.sv */
// Input channel: one sample of the button levels.
`default_nettype none
interface lvk_in_if;
  logic                        valid;
  logic                        ready;
  logic [lvk_pkg::FIELD_W-1:0] button_levels;

  modport source (output valid, output button_levels, input ready);
  modport sink   (input valid, input button_levels, output ready);
endinterface
`default_nettype wire

/* design/lvk_out_if.sv */
// Result channel: volume, learned key masks and changed flag.
`default_nettype none
interface lvk_out_if;
  logic                        valid;
  logic                        ready;
  logic [lvk_pkg::FIELD_W-1:0] volume_level;
  logic [lvk_pkg::FIELD_W-1:0] up_key_mask;
  logic [lvk_pkg::FIELD_W-1:0] down_key_mask;
  logic                        changed;

  modport source (output valid, output volume_level, output up_key_mask,
                  output down_key_mask, output changed, input ready);
  modport sink   (input valid, input volume_level, input up_key_mask,
                  input down_key_mask, input changed, output ready);
endinterface
`default_nettype wire

/* design/lvk_scan.sv */
// Edge detector and bit-serial edge scanner, lowest bit first.
`default_nettype none
module lvk_scan #(
  parameter int SCAN_BITS = lvk_pkg::BUTTONS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [lvk_pkg::FIELD_W-1:0] levels,
  output lvk_pkg::press_t                  press,
  output logic                             busy
);

  logic [SCAN_BITS-1:0]        last_r, last_nxt;
  logic [SCAN_BITS-1:0]        shift_r, shift_nxt;
  logic [lvk_pkg::FIELD_W-1:0] pos_r, pos_nxt;
  logic [SCAN_BITS-1:0]        lvl;

  assign lvl = levels[SCAN_BITS-1:0];

  always_comb begin
    last_nxt  = last_r;
    shift_nxt = shift_r;
    pos_nxt   = pos_r;
    if (start) begin
      last_nxt  = lvl;
      shift_nxt = lvl & ~last_r;
      pos_nxt   = lvk_pkg::FIELD_W'(1);
    end else if (busy) begin
      // advance one bit
      shift_nxt = shift_r >> 1;
      pos_nxt   = pos_r << 1;
    end
  end

  assign busy      = |shift_r;
  assign press.hit = shift_r[0];
  assign press.key = pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r  <= '0;
      shift_r <= '0;
    end else begin
      last_r  <= last_nxt;
      shift_r <= shift_nxt;
    end
    pos_r <= pos_nxt;
  end

endmodule
`default_nettype wire

/* design/lvk_key_unit.sv */
// Key learning, volume update and configuration registers.
`default_nettype none
module lvk_key_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           clear_changed,
  input  wire lvk_pkg::press_t                press,
  input  wire logic                           cfg_we,
  input  wire logic [lvk_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [lvk_pkg::CFG_DATA_W-1:0] cfg_data,
  output lvk_pkg::status_t                    status
);

  logic [lvk_pkg::STEP_W-1:0]  step_r;
  logic [lvk_pkg::FIELD_W-1:0] ceil_r;
  logic [lvk_pkg::FIELD_W-1:0] vol_r, vol_nxt;
  logic [lvk_pkg::FIELD_W-1:0] up_r, up_nxt;
  logic [lvk_pkg::FIELD_W-1:0] down_r, down_nxt;
  logic                        chg_r, chg_nxt;
  logic [lvk_pkg::FIELD_W-1:0] step_ext;
  logic [lvk_pkg::FIELD_W:0]   sum;
  logic                        is_up, is_down, act;

  assign step_ext = lvk_pkg::FIELD_W'(step_r);
  assign sum      = {1'b0, vol_r} + {1'b0, step_ext};
  assign is_up    = |(up_r & press.key);
  assign is_down  = |(down_r & press.key);

  always_comb begin
    vol_nxt  = vol_r;
    up_nxt   = up_r;
    down_nxt = down_r;
    act      = 1'b0;
    if (press.hit) begin
      if (up_r == '0) begin
        up_nxt = press.key;
        act    = 1'b1;
      end else if (down_r == '0 && !is_up) begin
        down_nxt = press.key;
        act      = 1'b1;
      end else if (is_up && vol_r < ceil_r) begin
        vol_nxt = (sum > {1'b0, ceil_r}) ? ceil_r : sum[lvk_pkg::FIELD_W-1:0];
        act     = 1'b1;
      end else if (is_down) begin
        vol_nxt = (vol_r >= step_ext) ? vol_r - step_ext : '0;
        act     = 1'b1;
      end
    end
    chg_nxt = clear_changed ? 1'b0 : (chg_r | act);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= lvk_pkg::STEP_RESET;
      ceil_r <= lvk_pkg::CEILING_RESET;
      vol_r  <= lvk_pkg::VOLUME_RESET;
      up_r   <= '0;
      down_r <= '0;
      chg_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          lvk_pkg::REG_STEP_SIZE:      step_r <= cfg_data[lvk_pkg::STEP_W-1:0];
          lvk_pkg::REG_VOLUME_CEILING: ceil_r <= cfg_data;
          default: ;
        endcase
      end
      vol_r  <= vol_nxt;
      up_r   <= up_nxt;
      down_r <= down_nxt;
      chg_r  <= chg_nxt;
    end
  end

  assign status.volume   = vol_r;
  assign status.up_mask  = up_r;
  assign status.down_key = down_r;
  assign status.changed  = chg_r;

endmodule
`default_nettype wire

/* design/learned_volume_key_controller_core.sv */
// Top level of the learned volume key controller.
`default_nettype none
// Each accepted sample of button levels is compared with the previous one;
// the newly pressed buttons (rising edges) are handled lowest bit first by a
// shift register that walks one bit per cycle over the edge bits. The first
// press ever seen is learned as the up key, the next press of another button
// as the down key; afterwards the up key adds step_size up to volume_ceiling
// and the down key subtracts it down to zero. One result per sample carries
// the volume, both learned masks and a changed flag. A sample occupies the
// block until the scan has passed its highest rising edge and its result
// has moved into the output register. A finished result waits in the output
// register while the next sample is taken; the scan holds its result only if
// the previous one has still not been taken. Buttons at or above BUTTONS are
// ignored. Write configuration only while the block is idle.
module learned_volume_key_controller_core #(
  parameter int BUTTONS = lvk_pkg::BUTTONS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  lvk_in_if.sink                              in_ch,
  lvk_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [lvk_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [lvk_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Only the first eight buttons are visible in the sample field.
  localparam int SCAN_BITS = (BUTTONS < lvk_pkg::FIELD_W) ? BUTTONS : lvk_pkg::FIELD_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic             state_r, state_nxt;
  logic             in_xfer;
  logic             scan_busy;
  logic             load_out;
  logic             out_valid_r, out_valid_nxt;
  lvk_pkg::press_t  press;
  lvk_pkg::status_t status;
  lvk_pkg::status_t res_r;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  lvk_scan #(
    .SCAN_BITS (SCAN_BITS)
  ) u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_xfer),
    .levels (in_ch.button_levels),
    .press  (press),
    .busy   (scan_busy)
  );

  lvk_key_unit u_key (
    .clk           (clk),
    .rst_n         (rst_n),
    .clear_changed (in_xfer),
    .press         (press),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_data      (cfg_data),
    .status        (status)
  );

  // Scan done: move the result into the output register once it is free.
  always_comb begin
    state_nxt     = state_r;
    load_out      = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!scan_busy && (!out_valid_r || out_ch.ready)) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (load_out) begin
      res_r <= status;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.volume_level  = res_r.volume;
  assign out_ch.up_key_mask   = res_r.up_mask;
  assign out_ch.down_key_mask = res_r.down_key;
  assign out_ch.changed       = res_r.changed;

endmodule
`default_nettype wire
